// ===== hw/rtl/scoped_lease_lock_table_defines.svh =====
// Assertion macros shared by the lease lock table RTL.
`ifndef SCOPED_LEASE_LOCK_TABLE_DEFINES_SVH
`define SCOPED_LEASE_LOCK_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define SLLT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lease table assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define SLLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lease table assertion failed");

`endif

// ===== hw/rtl/sllt_pkg.sv =====
// Types and constants of the scoped lease lock table.
package sllt_pkg;

  localparam int KEY_W    = 16;
  localparam int OWNER_W  = 2;
  localparam int LEASE_W  = 32;
  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] STATUS_GRANTED         = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_LEASE_BUSY      = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_CONTROL_BUSY    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_RELEASED        = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_RELEASE_IGNORED = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL      = 3'd5;

  localparam logic        OP_ACQUIRE = 1'b0;
  localparam logic        OP_RELEASE = 1'b1;

  localparam logic [OWNER_W-1:0] CLIENT_AGENT = 2'd0;
  localparam logic [OWNER_W-1:0] CLIENT_TOOL  = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [OWNER_W-1:0] owner;
    logic [LEASE_W-1:0] lease;
  } slot_t;

endpackage

// ===== hw/rtl/scoped_lease_lock_table.sv =====
// Scoped lease lock table: acquire and release of keyed and global leases.
// Each request item is checked against every slot of the table, one slot per cycle
// through a single compare unit fed by the single-port slot memory. After the last slot
// is read, a drain state lets that read reach the compare unit; the decide state then
// registers the result item once the output register is free or being drained.
// The next item may be accepted while that result still waits in the output register.
// Slot valid bits are flip-flops cleared by reset, so no clearing pass follows reset.
`include "scoped_lease_lock_table_defines.svh"

module scoped_lease_lock_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] target_key, [47:16] release_id
  input  logic [47:0] s_tdata,
  // [0] opcode, [2:1] client_type
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] status, [34:3] granted_id, [39:35] zero
  output logic [39:0] m_tdata
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  sllt_pkg::state_t state, state_next;

  logic                         s_accept;
  logic                         rd_en;
  logic                         decide_fire;

  logic                         req_op;
  logic [sllt_pkg::KEY_W-1:0]   req_key;
  logic [sllt_pkg::OWNER_W-1:0] req_client;
  logic [sllt_pkg::LEASE_W-1:0] req_rid;

  logic [IDX_W-1:0]             idx;
  logic                         ev_valid;
  logic [IDX_W-1:0]             ev_idx;
  logic                         ev_vbit;
  sllt_pkg::slot_t              rd_data;

  sllt_pkg::slot_t              mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]       valid;
  logic [sllt_pkg::LEASE_W-1:0] id_counter;

  logic                         key_found;
  logic [IDX_W-1:0]             key_idx;
  logic [sllt_pkg::OWNER_W-1:0] key_owner;
  logic                         key_lease_eq;
  logic                         glob_found;
  logic [sllt_pkg::OWNER_W-1:0] glob_owner;
  logic                         min_found;
  logic [sllt_pkg::KEY_W-1:0]   min_key;
  logic [sllt_pkg::OWNER_W-1:0] min_owner;
  logic                         free_found;
  logic [IDX_W-1:0]             free_idx;

  logic                         cmp_key_eq;
  logic                         cmp_zero;
  logic                         cmp_less;
  logic                         cmp_lease_eq;

  logic                         blk_found;
  logic [sllt_pkg::OWNER_W-1:0] blk_owner;
  logic                         do_grant;
  logic                         do_release;
  logic [sllt_pkg::STATUS_W-1:0] status_next;
  logic [sllt_pkg::LEASE_W-1:0] gid_next;

  logic [sllt_pkg::STATUS_W-1:0] out_status;
  logic [sllt_pkg::LEASE_W-1:0] out_gid;

  always_comb begin
    state_next = state;
    unique case (state)
      sllt_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = sllt_pkg::ST_SCAN;
        end
      end
      sllt_pkg::ST_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = sllt_pkg::ST_DRAIN;
        end
      end
      sllt_pkg::ST_DRAIN: begin
        state_next = sllt_pkg::ST_DECIDE;
      end
      sllt_pkg::ST_DECIDE: begin
        if (!m_tvalid || m_tready) begin
          state_next = sllt_pkg::ST_IDLE;
        end
      end
      default: state_next = sllt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    rd_en       = 1'b0;
    decide_fire = 1'b0;
    unique case (state)
      sllt_pkg::ST_IDLE:   s_tready = 1'b1;
      sllt_pkg::ST_SCAN:   rd_en = 1'b1;
      sllt_pkg::ST_DRAIN:  ;
      sllt_pkg::ST_DECIDE: decide_fire = !m_tvalid || m_tready;
      default:             ;
    endcase
  end

  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sllt_pkg::ST_IDLE;
      ev_valid <= 1'b0;
    end else begin
      state    <= state_next;
      ev_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      req_op     <= s_tuser[0];
      req_client <= s_tuser[2:1];
      req_key    <= s_tdata[15:0];
      req_rid    <= s_tdata[47:16];
      idx        <= '0;
    end else if (rd_en && idx != LAST_IDX) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[idx];
      ev_idx  <= idx;
      ev_vbit <= valid[idx];
    end
    if (decide_fire && do_grant) begin
      mem[free_idx] <= '{key: req_key, owner: req_client, lease: id_counter};
    end
  end

  assign cmp_key_eq   = rd_data.key == req_key;
  assign cmp_zero     = rd_data.key == '0;
  assign cmp_less     = !min_found || (rd_data.key < min_key);
  assign cmp_lease_eq = rd_data.lease == req_rid;

  always_ff @(posedge clk) begin
    if (s_accept) begin
      key_found  <= 1'b0;
      glob_found <= 1'b0;
      min_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (ev_valid) begin
      if (ev_vbit) begin
        if (cmp_key_eq) begin
          key_found    <= 1'b1;
          key_idx      <= ev_idx;
          key_owner    <= rd_data.owner;
          key_lease_eq <= cmp_lease_eq;
        end
        if (cmp_zero) begin
          glob_found <= 1'b1;
          glob_owner <= rd_data.owner;
        end
        if (cmp_less) begin
          min_found <= 1'b1;
          min_key   <= rd_data.key;
          min_owner <= rd_data.owner;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= ev_idx;
      end
    end
  end

  always_comb begin
    blk_found   = 1'b0;
    blk_owner   = min_owner;
    do_grant    = 1'b0;
    do_release  = 1'b0;
    gid_next    = '0;
    status_next = sllt_pkg::STATUS_RELEASE_IGNORED;
    if (req_op == sllt_pkg::OP_RELEASE) begin
      if (key_found && key_lease_eq) begin
        do_release  = 1'b1;
        status_next = sllt_pkg::STATUS_RELEASED;
      end
    end else begin
      if (req_key == '0) begin
        blk_found = min_found;
        blk_owner = min_owner;
      end else if (key_found) begin
        blk_found = 1'b1;
        blk_owner = key_owner;
      end else begin
        blk_found = glob_found;
        blk_owner = glob_owner;
      end
      if (blk_found) begin
        if (req_client == sllt_pkg::CLIENT_AGENT && blk_owner == sllt_pkg::CLIENT_TOOL) begin
          status_next = sllt_pkg::STATUS_CONTROL_BUSY;
        end else begin
          status_next = sllt_pkg::STATUS_LEASE_BUSY;
        end
      end else if (!free_found) begin
        status_next = sllt_pkg::STATUS_TABLE_FULL;
      end else begin
        do_grant    = 1'b1;
        gid_next    = id_counter;
        status_next = sllt_pkg::STATUS_GRANTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      id_counter <= sllt_pkg::LEASE_W'(1);
    end else if (decide_fire) begin
      if (do_grant) begin
        valid[free_idx] <= 1'b1;
        if (id_counter == '1) begin
          id_counter <= sllt_pkg::LEASE_W'(1);
        end else begin
          id_counter <= id_counter + 1'b1;
        end
      end
      if (do_release) begin
        valid[key_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (decide_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide_fire) begin
      out_status <= status_next;
      out_gid    <= gid_next;
    end
  end

  assign m_tdata = {5'b0, out_gid, out_status};

  `SLLT_ASSERT_NOW(a_id_never_zero, 1'b1, id_counter != '0)
  `SLLT_ASSERT_NOW(a_grant_has_id, m_tvalid && out_status == sllt_pkg::STATUS_GRANTED, out_gid != '0)
  `SLLT_ASSERT_NOW(a_refusal_no_id, m_tvalid && out_status != sllt_pkg::STATUS_GRANTED, out_gid == '0)
  `SLLT_ASSERT_NEXT(a_grant_sets_valid, decide_fire && do_grant, valid[$past(free_idx)])

endmodule
